>>> src/gsp_pkg.sv
// Shared types, constants and helpers for the grid shortest-path step block.
`default_nettype none

package gsp_pkg;

  // Grid geometry
  localparam int GRID_SIDE  = 8;
  localparam int CRD_W      = $clog2(GRID_SIDE);
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W      = $clog2(CELL_COUNT);

  // Field widths
  localparam int IN_CRD_W = 3;
  localparam int CNT_W    = 6;
  localparam int CFG_W    = 4;
  localparam int COST_W   = 10;
  localparam int FLAG_W   = 2;

  // Cell flag bits
  localparam int FLAG_ORE_BIT   = 0;
  localparam int FLAG_EMPTY_BIT = 1;

  // Request commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam int                 CFG_IDX_W     = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORE_COST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_COST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COST  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] ORE_COST_RST   = 4'd1;
  localparam logic [CFG_W-1:0] EMPTY_COST_RST = 4'd4;
  localparam logic [CFG_W-1:0] BASE_COST_RST  = 4'd3;

  // Neighbor directions, in sweep order
  localparam int               DIR_W   = 2;
  localparam logic [DIR_W-1:0] DIR_YP  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_YM  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_XP  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_XM  = 2'd3;

  // Step costs as programmed
  typedef struct packed {
    logic [CFG_W-1:0] ore_cost;
    logic [CFG_W-1:0] empty_cost;
    logic [CFG_W-1:0] base_cost;
  } cost_cfg_t;

  // Relaxation verdict for one edge
  typedef struct packed {
    logic              update;
    logic [COST_W-1:0] cand;
  } relax_res_t;

  // Saturate a coordinate to the last row or column
  function automatic logic [CRD_W-1:0] clamp_coord(input logic [IN_CRD_W-1:0] c);
    logic [CRD_W-1:0] r;
    if (int'(c) >= GRID_SIDE) r = CRD_W'(GRID_SIDE - 1);
    else r = CRD_W'(c);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/grid_shortest_path_step_top.sv
// Top level of the grid shortest-path step block: sequencer, map and path stores.
// Map load: one request per cycle while no query is in flight, no result. Query: when
//   source equals target the result skips the sweep; otherwise R relaxation rounds
//   (at most MAX_ROUNDS) over the reached cells, then L backtrack steps (at most 64).
//   One relaxation unit is reused for every edge, and each store has one read port.
// Synchronous active-low reset: costs return to ore 1, empty 4, base 3; map contents stay
//   undefined until loaded; no query in flight, no result pending.
`default_nettype none

module grid_shortest_path_step_top #(
  parameter int MAX_ROUNDS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration port
  input  wire logic                              cfg_we,
  input  wire logic [gsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gsp_pkg::CFG_W-1:0]         cfg_wdata,
  // Request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_command,
  input  wire logic [5:0]                        in_cell_index,
  input  wire logic                              in_cell_is_ore,
  input  wire logic                              in_cell_is_empty,
  input  wire logic [gsp_pkg::IN_CRD_W-1:0]      in_source_x,
  input  wire logic [gsp_pkg::IN_CRD_W-1:0]      in_source_y,
  input  wire logic [gsp_pkg::IN_CRD_W-1:0]      in_target_x,
  input  wire logic [gsp_pkg::IN_CRD_W-1:0]      in_target_y,
  // Result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [gsp_pkg::IN_CRD_W-1:0]           out_next_x,
  output logic [gsp_pkg::IN_CRD_W-1:0]           out_next_y,
  output logic [gsp_pkg::CNT_W-1:0]              out_blocks_needed
);
  import gsp_pkg::*;

  localparam int RND_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_HERE,
    S_DIR,
    S_RELAX,
    S_BT_RD,
    S_BT_CHK,
    S_FIN
  } state_t;

  state_t state_r;

  // Configuration
  cost_cfg_t cfg_r;

  // Sweep control
  logic [CRD_W-1:0]      x_r, y_r;
  logic [DIR_W-1:0]      dir_r;
  logic [RND_W-1:0]      round_r;
  logic                  changed_r;
  logic [COST_W-1:0]     here_cost_r;
  logic [CELL_COUNT-1:0] valid_r;
  logic [IDX_W-1:0]      src_r, tgt_r;

  // Backtrack control
  logic [IDX_W-1:0] cur_r;
  logic [IDX_W-1:0] bt_n_r;
  logic [CNT_W-1:0] cnt_r;

  // Pending result and output register
  logic [CRD_W-1:0] res_x_r, res_y_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic             out_valid_r;
  logic [CRD_W-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0] out_cnt_r;

  // Query decode
  logic [CRD_W-1:0] sx, sy, tx, ty;
  logic [IDX_W-1:0] q_src, q_tgt;
  logic             accept, acc_load, acc_query, q_same;

  assign sx        = clamp_coord(in_source_x);
  assign sy        = clamp_coord(in_source_y);
  assign tx        = clamp_coord(in_target_x);
  assign ty        = clamp_coord(in_target_y);
  assign q_src     = {sy, sx};
  assign q_tgt     = {ty, tx};
  assign q_same    = (sx == tx) && (sy == ty);
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign acc_load  = accept && (in_command == CMD_LOAD);
  assign acc_query = accept && (in_command == CMD_QUERY);

  // Neighbor of the current cell in the current direction
  logic [IDX_W-1:0] here_idx, nb_idx;
  logic [CRD_W-1:0] nb_x, nb_y;
  logic             nb_ok;

  assign here_idx = {y_r, x_r};

  always_comb begin
    nb_x  = x_r;
    nb_y  = y_r;
    nb_ok = 1'b0;
    unique case (dir_r)
      DIR_YP: begin
        nb_y  = y_r + 1'b1;
        nb_ok = (y_r != CRD_W'(GRID_SIDE - 1));
      end
      DIR_YM: begin
        nb_y  = y_r - 1'b1;
        nb_ok = (y_r != '0);
      end
      DIR_XP: begin
        nb_x  = x_r + 1'b1;
        nb_ok = (x_r != CRD_W'(GRID_SIDE - 1));
      end
      DIR_XM: begin
        nb_x  = x_r - 1'b1;
        nb_ok = (x_r != '0);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_idx = {nb_y, nb_x};

  // Stores
  logic [FLAG_W-1:0] flag_rdata;
  logic [COST_W-1:0] cost_rdata;
  logic [IDX_W-1:0]  pred_rdata;
  logic              flag_we, cost_we, pred_we;
  logic [IDX_W-1:0]  flag_raddr, cost_raddr, cost_waddr;
  logic [COST_W-1:0] cost_wdata;
  relax_res_t        relax;
  logic              upd_now;

  assign upd_now    = (state_r == S_RELAX) && relax.update;
  assign flag_we    = acc_load && (int'(in_cell_index) < CELL_COUNT);
  assign flag_raddr = (state_r == S_BT_RD) ? cur_r : nb_idx;
  assign cost_raddr = (state_r == S_CELL) ? here_idx : nb_idx;
  assign cost_we    = (acc_query && !q_same) || upd_now;
  assign cost_waddr = (state_r == S_IDLE) ? q_src : nb_idx;
  assign cost_wdata = (state_r == S_IDLE) ? '0 : relax.cand;
  assign pred_we    = upd_now;

  gsp_ram #(.WIDTH(FLAG_W), .DEPTH(CELL_COUNT)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (IDX_W'(in_cell_index)),
    .wdata ({in_cell_is_empty, in_cell_is_ore}),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  gsp_ram #(.WIDTH(COST_W), .DEPTH(CELL_COUNT)) u_cost_ram (
    .clk   (clk),
    .we    (cost_we),
    .waddr (cost_waddr),
    .wdata (cost_wdata),
    .raddr (cost_raddr),
    .rdata (cost_rdata)
  );

  gsp_ram #(.WIDTH(IDX_W), .DEPTH(CELL_COUNT)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (nb_idx),
    .wdata (here_idx),
    .raddr (cur_r),
    .rdata (pred_rdata)
  );

  // Shared relaxation unit
  gsp_relax u_relax (
    .cfg         (cfg_r),
    .flags       (flag_rdata),
    .here_cost   (here_cost_r),
    .there_cost  (cost_rdata),
    .there_valid (valid_r[nb_idx]),
    .res         (relax)
  );

  // Sweep bookkeeping
  logic last_dir, last_y, last_x, last_round, changed_eff, tgt_reached;
  logic [CNT_W-1:0] cnt_new;

  assign last_dir    = (dir_r == DIR_XM);
  assign last_y      = (y_r == CRD_W'(GRID_SIDE - 1));
  assign last_x      = (x_r == CRD_W'(GRID_SIDE - 1));
  assign last_round  = (round_r == RND_W'(MAX_ROUNDS - 1));
  assign changed_eff = changed_r || upd_now;
  assign tgt_reached = valid_r[tgt_r] || (upd_now && (nb_idx == tgt_r));
  assign cnt_new     = (flag_rdata[FLAG_EMPTY_BIT] && (cnt_r != '1)) ? cnt_r + 1'b1 : cnt_r;

  // Sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      valid_r          <= '0;
      changed_r        <= 1'b0;
      cfg_r.ore_cost   <= ORE_COST_RST;
      cfg_r.empty_cost <= EMPTY_COST_RST;
      cfg_r.base_cost  <= BASE_COST_RST;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ORE_COST:   cfg_r.ore_cost   <= cfg_wdata;
          CFG_EMPTY_COST: cfg_r.empty_cost <= cfg_wdata;
          CFG_BASE_COST:  cfg_r.base_cost  <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result once taken
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (acc_query) begin
            src_r <= q_src;
            tgt_r <= q_tgt;
            if (q_same) begin
              res_x_r   <= tx;
              res_y_r   <= ty;
              res_cnt_r <= '0;
              state_r   <= S_FIN;
            end else begin
              valid_r   <= CELL_COUNT'(1) << q_src;
              x_r       <= '0;
              y_r       <= '0;
              round_r   <= '0;
              changed_r <= 1'b0;
              state_r   <= S_CELL;
            end
          end
        end

        S_CELL: begin
          if (valid_r[here_idx]) begin
            state_r <= S_HERE;
          end else begin
            // Skip unreached cell
            if (last_y) begin
              y_r <= '0;
              x_r <= x_r + 1'b1;
            end else begin
              y_r <= y_r + 1'b1;
            end
            if (last_y && last_x) begin
              if (!changed_eff || last_round) begin
                cur_r  <= tgt_r;
                bt_n_r <= '0;
                cnt_r  <= '0;
                if (tgt_reached) begin
                  state_r <= S_BT_RD;
                end else begin
                  res_x_r   <= tgt_r[CRD_W-1:0];
                  res_y_r   <= tgt_r[IDX_W-1:CRD_W];
                  res_cnt_r <= '0;
                  state_r   <= S_FIN;
                end
              end else begin
                round_r   <= round_r + 1'b1;
                changed_r <= 1'b0;
                state_r   <= S_CELL;
              end
            end else begin
              state_r <= S_CELL;
            end
          end
        end

        S_HERE: begin
          here_cost_r <= cost_rdata;
          dir_r       <= DIR_YP;
          state_r     <= S_DIR;
        end

        S_DIR, S_RELAX: begin
          if ((state_r == S_DIR) && nb_ok) begin
            state_r <= S_RELAX;
          end else begin
            // Record the update and advance to the next direction or cell
            if (upd_now) begin
              valid_r[nb_idx] <= 1'b1;
              changed_r       <= 1'b1;
            end
            if (!last_dir) begin
              dir_r   <= dir_r + 1'b1;
              state_r <= S_DIR;
            end else begin
              if (last_y) begin
                y_r <= '0;
                x_r <= x_r + 1'b1;
              end else begin
                y_r <= y_r + 1'b1;
              end
              if (last_y && last_x) begin
                if (!changed_eff || last_round) begin
                  cur_r  <= tgt_r;
                  bt_n_r <= '0;
                  cnt_r  <= '0;
                  if (tgt_reached) begin
                    state_r <= S_BT_RD;
                  end else begin
                    res_x_r   <= tgt_r[CRD_W-1:0];
                    res_y_r   <= tgt_r[IDX_W-1:CRD_W];
                    res_cnt_r <= '0;
                    state_r   <= S_FIN;
                  end
                end else begin
                  round_r   <= round_r + 1'b1;
                  changed_r <= 1'b0;
                  state_r   <= S_CELL;
                end
              end else begin
                state_r <= S_CELL;
              end
            end
          end
        end

        S_BT_RD: begin
          state_r <= S_BT_CHK;
        end

        S_BT_CHK: begin
          // Walk one predecessor link toward the source
          if (pred_rdata == src_r) begin
            res_x_r   <= cur_r[CRD_W-1:0];
            res_y_r   <= cur_r[IDX_W-1:CRD_W];
            res_cnt_r <= cnt_new;
            state_r   <= S_FIN;
          end else if (bt_n_r == IDX_W'(CELL_COUNT - 1)) begin
            res_x_r   <= tgt_r[CRD_W-1:0];
            res_y_r   <= tgt_r[IDX_W-1:CRD_W];
            res_cnt_r <= '0;
            state_r   <= S_FIN;
          end else begin
            cur_r   <= pred_rdata;
            bt_n_r  <= bt_n_r + 1'b1;
            cnt_r   <= cnt_new;
            state_r <= S_BT_RD;
          end
        end

        S_FIN: begin
          // Hand the result to the output register once it is free
          if (!out_valid_r || !out_stall) begin
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_cnt_r   <= res_cnt_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_x        = IN_CRD_W'(out_x_r);
  assign out_next_y        = IN_CRD_W'(out_y_r);
  assign out_blocks_needed = out_cnt_r;

endmodule

`default_nettype wire

>>> src/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/gsp_relax.sv
// Shared relaxation unit: entry cost lookup, add and compare for one edge.
`default_nettype none

module gsp_relax (
  input  wire gsp_pkg::cost_cfg_t          cfg,
  input  wire logic [gsp_pkg::FLAG_W-1:0]  flags,
  input  wire logic [gsp_pkg::COST_W-1:0]  here_cost,
  input  wire logic [gsp_pkg::COST_W-1:0]  there_cost,
  input  wire logic                        there_valid,
  output gsp_pkg::relax_res_t              res
);
  import gsp_pkg::*;

  logic [CFG_W-1:0]  step_cost;
  logic [COST_W-1:0] cand;

  // Pick the cost of entering the neighbor; ore wins over empty
  always_comb begin
    priority if (flags[FLAG_ORE_BIT]) begin
      step_cost = cfg.ore_cost;
    end else if (flags[FLAG_EMPTY_BIT]) begin
      step_cost = cfg.empty_cost;
    end else begin
      step_cost = cfg.base_cost;
    end
  end

  // Candidate cost and strict-improvement test
  assign cand       = here_cost + COST_W'(step_cost);
  assign res.cand   = cand;
  assign res.update = !there_valid || (there_cost > cand);

endmodule

`default_nettype wire
